### hdl/bsc_pkg.sv
// Shared types and constants for the barometric sensor compensation block.
// Used by every module under hdl; depends on nothing else.
package bsc_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_AC_FIRST  = 3'd0;
    localparam logic [2:0] CFG_AC_SECOND = 3'd1;
    localparam logic [2:0] CFG_B_PAIR    = 3'd2;
    localparam logic [2:0] CFG_M_PAIR    = 3'd3;
    localparam logic [2:0] CFG_OSS       = 3'd4;

    localparam int CFG_DATA_W = 48;
    localparam logic [1:0] OSS_RESET = 2'd1;

    // Request kinds.
    localparam logic KIND_TEMP  = 1'b0;
    localparam logic KIND_PRESS = 1'b1;

    // Compensation constants.
    localparam logic signed [31:0] B6_OFFSET  = 32'sd4000;
    localparam logic [31:0]        B7_SCALE   = 32'd50000;
    localparam logic signed [43:0] B4_OFFSET  = 44'sd32768;
    localparam logic signed [31:0] P_SQ_COEF  = 32'sd3038;
    localparam logic signed [31:0] P_LIN_COEF = -32'sd7357;
    localparam logic signed [55:0] P_BIAS     = 56'sd3791;

    // Iteration counts of the shared arithmetic units.
    localparam int MUL_DIGITS = 4;
    localparam int DIV_STEPS  = 34;

    typedef struct packed {
        logic        req_type;
        logic [23:0] raw_value;
    } in_t;

    typedef struct packed {
        logic               result_kind;
        logic signed [31:0] value;
        logic               status;
    } out_t;

    // Micro-steps of the compensation sequence; each one is a multiply.
    typedef enum logic [3:0] {
        STEP_T1  = 4'd0,
        STEP_P1  = 4'd1,
        STEP_P2  = 4'd2,
        STEP_P3  = 4'd3,
        STEP_P4  = 4'd4,
        STEP_P5  = 4'd5,
        STEP_P6  = 4'd6,
        STEP_P7  = 4'd7,
        STEP_P8  = 4'd8,
        STEP_P9  = 4'd9,
        STEP_P10 = 4'd10
    } step_t;

    typedef struct packed {
        logic  load;
        logic  mul_start;
        logic  mul_capture;
        logic  div_start;
        logic  div_capture;
        logic  check;
        logic  emit;
        step_t step;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic is_pressure;
        logic zero_div;
    } sts_t;

endpackage

### hdl/bsc_mul.sv
// Sequential signed multiplier: 64-bit by 32-bit, one 8-bit digit per cycle.
// Depends on bsc_pkg for the digit count.
module bsc_mul (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] a,
    input  logic signed [31:0] b,
    output logic               done,
    output logic signed [63:0] product
);

    logic signed [63:0] a_reg, a_next;
    logic signed [31:0] b_reg, b_next;
    logic signed [63:0] acc_reg, acc_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic signed [8:0]  dig;
    logic signed [63:0] pp;

    // Low digits are unsigned, the top digit carries the sign.
    assign dig = (cnt_reg == 2'(bsc_pkg::MUL_DIGITS - 1)) ? {b_reg[7], b_reg[7:0]}
                                                         : {1'b0, b_reg[7:0]};
    assign pp  = a_reg * dig;

    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = acc_reg + pp;
            a_next   = a_reg <<< 8;
            b_next   = b_reg >>> 8;
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'(bsc_pkg::MUL_DIGITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

### hdl/bsc_div.sv
// Restoring unsigned divider: 34-bit dividend by 32-bit divisor, one bit per cycle.
// Depends on bsc_pkg for the step count.
module bsc_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [33:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [33:0] quotient
);

    logic [33:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] sh;
    logic [32:0] diff;
    logic        fits;

    assign sh   = {rem_reg, quo_reg[33]};
    assign diff = sh - {1'b0, dvs_reg};
    assign fits = (sh >= {1'b0, dvs_reg});

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[31:0] : sh[31:0];
            quo_next = {quo_reg[32:0], fits};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(bsc_pkg::DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### hdl/bsc_datapath.sv
// Datapath: calibration registers, intermediates, output register and the
// shared multiplier and divider. Depends on bsc_pkg, bsc_mul and bsc_div.
module bsc_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [2:0]                        cfg_index,
    input  logic [bsc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  bsc_pkg::in_t                      s_data,
    input  bsc_pkg::cmd_t                     cmd,
    output bsc_pkg::sts_t                     sts,
    output bsc_pkg::out_t                     m_data
);

    logic [47:0] ac_first_reg, ac_second_reg;
    logic [31:0] b_pair_reg, m_pair_reg;
    logic [1:0]  oss_reg;

    logic               kind_reg;
    logic [23:0]        raw_reg;
    logic signed [31:0] b5_reg;
    logic signed [31:0] b6_reg;
    logic signed [17:0] x1_reg;
    logic signed [18:0] den_reg;
    logic signed [42:0] sq_reg;
    logic signed [47:0] x3_reg;
    logic signed [43:0] y_reg;
    logic [31:0]        b3_reg, b4_reg, b7_reg;
    logic [33:0]        p_reg;
    logic signed [53:0] t1_reg;
    logic signed [31:0] result_reg;
    logic               status_reg;
    bsc_pkg::out_t      out_reg;

    logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [15:0]        ac4, ac5, ac6;

    assign ac1 = $signed(ac_first_reg[47:32]);
    assign ac2 = $signed(ac_first_reg[31:16]);
    assign ac3 = $signed(ac_first_reg[15:0]);
    assign ac4 = ac_second_reg[47:32];
    assign ac5 = ac_second_reg[31:16];
    assign ac6 = ac_second_reg[15:0];
    assign b1  = $signed(b_pair_reg[31:16]);
    assign b2  = $signed(b_pair_reg[15:0]);
    assign mc  = $signed(m_pair_reg[31:16]);
    assign md  = $signed(m_pair_reg[15:0]);

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ac_first_reg  <= '0;
            ac_second_reg <= '0;
            b_pair_reg    <= '0;
            m_pair_reg    <= '0;
            oss_reg       <= bsc_pkg::OSS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                bsc_pkg::CFG_AC_FIRST:  ac_first_reg  <= cfg_data;
                bsc_pkg::CFG_AC_SECOND: ac_second_reg <= cfg_data;
                bsc_pkg::CFG_B_PAIR:    b_pair_reg    <= cfg_data[31:0];
                bsc_pkg::CFG_M_PAIR:    m_pair_reg    <= cfg_data[31:0];
                bsc_pkg::CFG_OSS:       oss_reg       <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Shared arithmetic units.
    logic               mul_done, div_done;
    logic signed [63:0] mul_a, prod;
    logic signed [31:0] mul_b;
    logic [33:0]        div_n, quo;
    logic [31:0]        div_d;

    bsc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (prod)
    );

    bsc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (quo)
    );

    // Operand selection.
    logic signed [16:0] ut_diff;
    logic [18:0]        up_w;
    logic [31:0]        up_minus_b3;

    assign ut_diff     = $signed({1'b0, raw_reg[15:0]}) - $signed({1'b0, ac6});
    assign up_w        = 19'(raw_reg >> (4'd8 - {2'b00, oss_reg}));
    assign up_minus_b3 = {13'd0, up_w} - b3_reg;

    always_comb begin
        unique case (cmd.step)
            bsc_pkg::STEP_T1: begin
                mul_a = 64'(ut_diff);
                mul_b = $signed({16'd0, ac5});
            end
            bsc_pkg::STEP_P1: begin
                mul_a = 64'(b6_reg);
                mul_b = b6_reg;
            end
            bsc_pkg::STEP_P2: begin
                mul_a = 64'(sq_reg);
                mul_b = 32'(b2);
            end
            bsc_pkg::STEP_P3: begin
                mul_a = 64'(ac2);
                mul_b = b6_reg;
            end
            bsc_pkg::STEP_P4: begin
                mul_a = 64'(ac3);
                mul_b = b6_reg;
            end
            bsc_pkg::STEP_P5: begin
                mul_a = 64'(sq_reg);
                mul_b = 32'(b1);
            end
            bsc_pkg::STEP_P6: begin
                mul_a = 64'(y_reg);
                mul_b = $signed({16'd0, ac4});
            end
            bsc_pkg::STEP_P7: begin
                mul_a = $signed({32'd0, up_minus_b3});
                mul_b = $signed(bsc_pkg::B7_SCALE >> oss_reg);
            end
            bsc_pkg::STEP_P8: begin
                mul_a = $signed({38'd0, p_reg[33:8]});
                mul_b = $signed({6'd0, p_reg[33:8]});
            end
            bsc_pkg::STEP_P9: begin
                mul_a = 64'(t1_reg);
                mul_b = bsc_pkg::P_SQ_COEF;
            end
            bsc_pkg::STEP_P10: begin
                mul_a = $signed({30'd0, p_reg});
                mul_b = bsc_pkg::P_LIN_COEF;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Divider operands: signed temperature division runs on magnitudes.
    logic signed [26:0] mc_sh;
    logic [26:0]        mc_mag;
    logic [18:0]        den_mag;
    logic               q_neg;

    assign mc_sh   = 27'(mc) <<< 11;
    assign mc_mag  = mc_sh[26] ? 27'(-mc_sh) : 27'(mc_sh);
    assign den_mag = den_reg[18] ? 19'(-den_reg) : 19'(den_reg);
    assign q_neg   = mc_sh[26] ^ den_reg[18];

    always_comb begin
        if (kind_reg == bsc_pkg::KIND_TEMP) begin
            div_n = {7'd0, mc_mag};
            div_d = {13'd0, den_mag};
        end else if (b7_reg[31]) begin
            div_n = {2'd0, b7_reg};
            div_d = b4_reg;
        end else begin
            div_n = {1'b0, b7_reg, 1'b0};
            div_d = b4_reg;
        end
    end

    function automatic logic [31:0] calc_b3(input logic signed [15:0] c1,
                                            input logic signed [47:0] x3,
                                            input logic [1:0] oss);
        logic signed [63:0] v;
        logic signed [63:0] q;
        v = ((64'(c1) <<< 2) + 64'(x3)) <<< oss;
        v = v + 64'sd2;
        q = (v + (v[63] ? 64'sd3 : 64'sd0)) >>> 2;
        return q[31:0];
    endfunction

    // Values formed when a unit finishes.
    logic signed [17:0] x1_new;
    logic signed [43:0] y_sum;
    logic signed [55:0] corr_sum;
    logic signed [55:0] p_final;
    logic signed [33:0] x2;
    logic signed [31:0] b5_new;
    logic signed [32:0] t_round;

    assign x1_new   = $signed(prod[32:15]);
    assign y_sum    = y_reg + $signed(prod[59:16]) + 44'sd2;
    assign corr_sum = 56'(t1_reg) + 56'($signed(prod[63:16])) + bsc_pkg::P_BIAS;
    assign p_final  = $signed({22'd0, p_reg}) + (corr_sum >>> 4);
    assign x2       = q_neg ? -$signed(quo) : $signed(quo);
    assign b5_new   = 32'(34'(x1_reg) + x2);
    assign t_round  = 33'(b5_new) + 33'sd8;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b5_reg <= '0;
        end else if (cmd.div_capture && kind_reg == bsc_pkg::KIND_TEMP) begin
            b5_reg <= b5_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg   <= s_data.req_type;
            raw_reg    <= s_data.raw_value;
            b6_reg     <= b5_reg - bsc_pkg::B6_OFFSET;
            result_reg <= '0;
            status_reg <= 1'b0;
        end
        if (cmd.check && sts.zero_div) begin
            status_reg <= 1'b1;
        end
        if (cmd.mul_capture) begin
            unique case (cmd.step)
                bsc_pkg::STEP_T1: begin
                    x1_reg  <= x1_new;
                    den_reg <= 19'(x1_new) + 19'(md);
                end
                bsc_pkg::STEP_P1: sq_reg <= $signed(prod[54:12]);
                bsc_pkg::STEP_P2: x3_reg <= $signed(prod[58:11]);
                bsc_pkg::STEP_P3: x3_reg <= x3_reg + $signed(prod[58:11]);
                bsc_pkg::STEP_P4: begin
                    y_reg  <= $signed(prod[56:13]);
                    b3_reg <= calc_b3(ac1, x3_reg, oss_reg);
                end
                bsc_pkg::STEP_P5: y_reg <= (y_sum >>> 2) + bsc_pkg::B4_OFFSET;
                bsc_pkg::STEP_P6: b4_reg <= prod[46:15];
                bsc_pkg::STEP_P7: b7_reg <= prod[31:0];
                bsc_pkg::STEP_P8: t1_reg <= $signed(prod[53:0]);
                bsc_pkg::STEP_P9: t1_reg <= 54'($signed(prod[63:16]));
                bsc_pkg::STEP_P10: result_reg <= p_final[31:0];
                default: ;
            endcase
        end
        if (cmd.div_capture) begin
            if (kind_reg == bsc_pkg::KIND_TEMP) begin
                result_reg <= 32'(t_round >>> 4);
            end else begin
                // The doubled quotient of a large b7 wraps at 32 bits.
                p_reg <= b7_reg[31] ? {2'b00, quo[30:0], 1'b0} : quo;
            end
        end
        if (cmd.emit) begin
            out_reg.result_kind <= kind_reg;
            out_reg.value       <= result_reg;
            out_reg.status      <= status_reg;
        end
    end

    assign sts.mul_done    = mul_done;
    assign sts.div_done    = div_done;
    assign sts.is_pressure = kind_reg;
    assign sts.zero_div    = (kind_reg == bsc_pkg::KIND_PRESS) ? (b4_reg == 32'd0)
                                                               : (den_reg == 19'sd0);
    assign m_data = out_reg;

endmodule

### hdl/bsc_ctrl.sv
// Controller: sequences multiply and divide steps and owns both handshakes.
// Depends on bsc_pkg for the command, status and step types.
module bsc_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          in_kind,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  bsc_pkg::sts_t sts,
    output bsc_pkg::cmd_t cmd
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_MUL_GO   = 7'b0000010,
        ST_MUL_WAIT = 7'b0000100,
        ST_CHECK    = 7'b0001000,
        ST_DIV_GO   = 7'b0010000,
        ST_DIV_WAIT = 7'b0100000,
        ST_DONE     = 7'b1000000
    } state_t;

    state_t         state_reg, state_next;
    bsc_pkg::step_t step_reg, step_next;
    logic           out_valid_reg, out_valid_next;

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.step       = step_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    step_next  = in_kind ? bsc_pkg::STEP_P1 : bsc_pkg::STEP_T1;
                    state_next = ST_MUL_GO;
                end
            end
            ST_MUL_GO: begin
                cmd.mul_start = 1'b1;
                state_next    = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
                if (sts.mul_done) begin
                    cmd.mul_capture = 1'b1;
                    priority if (step_reg == bsc_pkg::STEP_T1 ||
                                 step_reg == bsc_pkg::STEP_P7) begin
                        state_next = ST_CHECK;
                    end else if (step_reg == bsc_pkg::STEP_P10) begin
                        state_next = ST_DONE;
                    end else begin
                        step_next  = bsc_pkg::step_t'(step_reg + 4'd1);
                        state_next = ST_MUL_GO;
                    end
                end
            end
            ST_CHECK: begin
                cmd.check  = 1'b1;
                state_next = sts.zero_div ? ST_DONE : ST_DIV_GO;
            end
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (sts.div_done) begin
                    cmd.div_capture = 1'b1;
                    if (sts.is_pressure) begin
                        step_next  = bsc_pkg::STEP_P8;
                        state_next = ST_MUL_GO;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= bsc_pkg::STEP_T1;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_mul_done_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.mul_done |-> state_reg == ST_MUL_WAIT)
        else $error("multiplier finished outside its wait state");
    a_div_done_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.div_done |-> state_reg == ST_DIV_WAIT)
        else $error("divider finished outside its wait state");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_valid_reg && !m_ready) |=> state_reg == ST_DONE)
        else $error("pending result would be overwritten");
    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> out_valid_reg)
        else $error("emitted result not presented");
`endif

endmodule

### hdl/baro_sensor_compensation.sv
// Top level of the barometric sensor temperature and pressure compensation.
// Depends on bsc_pkg, bsc_ctrl and bsc_datapath.
//
//   Channel  Direction  Handshake            Payload
//   s_       in         s_valid / s_ready    bsc_pkg::in_t  (req_type, raw_value)
//   m_       out        m_valid / m_ready    bsc_pkg::out_t (result_kind, value, status)
//   cfg_     in         cfg_we (no wait)     cfg_index, cfg_data
//
// A temperature item holds the block from its transfer to the next possible one,
// a pressure item longer, set by one shared 64x32 multiplier that handles one
// 8-bit digit per cycle and a 34-step bit-serial divider. A zero divisor skips
// the division, for temperature and pressure alike.
// One item is in work at a time; the next transfer is taken once the result is
// moved into the output register, even while that result still waits for m_ready.
// A stalled output holds the finished item in its last state until room frees up.
// Reset is synchronous on aresetn low; it clears control state, the stored b5
// and the calibration registers, with oversampling returning to one.
module baro_sensor_compensation (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [2:0]                     cfg_index,
    input  logic [bsc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  bsc_pkg::in_t                   s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output bsc_pkg::out_t                  m_data
);

    bsc_pkg::cmd_t cmd;
    bsc_pkg::sts_t sts;

    // The controller walks the compensation steps; the datapath does the math.
    bsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .in_kind (s_data.req_type),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bsc_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_data    (m_data)
    );

endmodule

### dv/testbench.sv
// Self-checking testbench for baro_sensor_compensation: temperature and pressure
// compensation checked against an in-bench integer predictor. Depends on bsc_pkg.
module testbench;

    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [2:0] CFG_UNUSED_INDEX = 3'd7;

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_we;
    logic [2:0]                     cfg_index;
    logic [bsc_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           s_valid;
    logic                           s_ready;
    bsc_pkg::in_t                   s_data;
    logic                           m_valid;
    logic                           m_ready;
    bsc_pkg::out_t                  m_data;

    baro_sensor_compensation dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // The predictor keeps its own copy of the calibration and of the stored b5.
    logic [47:0]        coef_ac_first;
    logic [47:0]        coef_ac_second;
    logic [31:0]        coef_b_pair;
    logic [31:0]        coef_m_pair;
    logic [1:0]         coef_oss;
    logic signed [31:0] model_b5;

    bsc_pkg::in_t  pending_items[$];
    bsc_pkg::out_t expected_results[$];

    int  error_count;
    int  cycle_count;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_hold = 1'b0;
    int  hold_cycles;
    bit  send_pause;
    int  sent_count = 0;
    int  taken_count = 0;

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // Arithmetic shift on 64-bit signed values: >>> floors, as required.
    function automatic bsc_pkg::out_t compensate(input bsc_pkg::in_t item);
        bsc_pkg::out_t      res;
        logic signed [63:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic signed [63:0] ut, x1, den, x2, b6, sq, x3, b3w, y, p, t1, t2;
        logic [31:0]        up, b3, b4, b7;
        logic [63:0]        prod;
        int                 oss;
        ac1 = 64'(signed'(coef_ac_first[47:32]));
        ac2 = 64'(signed'(coef_ac_first[31:16]));
        ac3 = 64'(signed'(coef_ac_first[15:0]));
        ac4 = {48'd0, coef_ac_second[47:32]};
        ac5 = {48'd0, coef_ac_second[31:16]};
        ac6 = {48'd0, coef_ac_second[15:0]};
        b1  = 64'(signed'(coef_b_pair[31:16]));
        b2  = 64'(signed'(coef_b_pair[15:0]));
        mc  = 64'(signed'(coef_m_pair[31:16]));
        md  = 64'(signed'(coef_m_pair[15:0]));
        res.result_kind = item.req_type;
        res.value = '0;
        res.status = 1'b0;
        if (item.req_type == bsc_pkg::KIND_TEMP) begin
            ut = {48'd0, item.raw_value[15:0]};
            x1 = ((ut - ac6) * ac5) >>> 15;
            den = x1 + md;
            if (den == 0) begin
                res.status = 1'b1;
            end else begin
                x2 = (mc * 2048) / den;
                model_b5 = 32'(x1 + x2);
                res.value = 32'((64'(model_b5) + 8) >>> 4);
            end
        end else begin
            oss = int'(coef_oss);
            up = 32'(item.raw_value >> (8 - oss));
            b6 = 64'(model_b5) - 4000;
            sq = (b6 * b6) >>> 12;
            x3 = ((b2 * sq) >>> 11) + ((ac2 * b6) >>> 11);
            b3w = ((ac1 * 4 + x3) * (64'sd1 <<< oss) + 2) / 4;
            b3 = 32'(b3w);
            y = (((ac3 * b6) >>> 13) + ((b1 * sq) >>> 16) + 2) >>> 2;
            prod = 64'(ac4) * 64'(y + 32768);
            b4 = 32'(prod >> 15);
            b7 = (up - b3) * (32'd50000 >> oss);
            if (b4 == 0) begin
                res.status = 1'b1;
            end else begin
                if (b7 < 32'h8000_0000) p = 64'(({32'd0, b7} * 2) / {32'd0, b4});
                else p = {32'd0, (b7 / b4) * 32'd2};
                t1 = (p >>> 8) * (p >>> 8);
                t1 = (t1 * 3038) >>> 16;
                t2 = (-64'sd7357 * p) >>> 16;
                p = p + ((t1 + t2 + 3791) >>> 4);
                res.value = 32'(p);
            end
        end
        return res;
    endfunction

    // Driver: valid stays up with a steady payload until the transfer.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && taken_count != sent_count) begin
            // Hold the offered item.
        end else if (pending_items.size() > 0 && !send_pause &&
                     $urandom_range(99) >= send_idle_pct) begin
            s_valid <= 1'b1;
            s_data <= pending_items.pop_front();
            sent_count <= sent_count + 1;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Prediction happens at the transfer, so config changes only between phases.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            expected_results.push_back(compensate(s_data));
            taken_count <= taken_count + 1;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (recv_hold) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // The receiver's long hold-off is counted in its own process.
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            recv_hold <= (hold_cycles > 1);
        end else begin
            recv_hold <= 1'b0;
        end
    end

    // Monitor: each result transfer is checked against the oldest prediction.
    always @(posedge aclk) begin
        bsc_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= 10) $display("unexpected result %p", m_data);
            end else begin
                want = expected_results.pop_front();
                if (want.result_kind !== m_data.result_kind || want.value !== m_data.value ||
                    want.status !== m_data.status) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: expected kind %0d value %0d status %0d, got %0d %0d %0d",
                                 want.result_kind, want.value, want.status,
                                 m_data.result_kind, m_data.value, m_data.status);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx,
                             input logic [bsc_pkg::CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            bsc_pkg::CFG_AC_FIRST:  coef_ac_first = val;
            bsc_pkg::CFG_AC_SECOND: coef_ac_second = val;
            bsc_pkg::CFG_B_PAIR:    coef_b_pair = val[31:0];
            bsc_pkg::CFG_M_PAIR:    coef_m_pair = val[31:0];
            bsc_pkg::CFG_OSS:       coef_oss = val[1:0];
            default: ;
        endcase
    endtask

    // Waits for the block to drain, then lets it settle a little longer.
    task automatic drain();
        while (pending_items.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    // Datasheet-like calibration perturbed at random (mode 0), all ones (1), mostly 16'h8000 (2), random (3).
    task automatic load_calibration(input int mode);
        logic [15:0] c[11];
        foreach (c[i]) c[i] = 16'($urandom);
        if (mode == 0) begin
            c[0] = 16'(408 + $urandom_range(200)); c[1] = -16'(72 + $urandom_range(100));
            c[2] = -16'(14383 + $urandom_range(500)); c[3] = 16'(32741 + $urandom_range(500));
            c[4] = 16'(32757 - $urandom_range(500)); c[5] = 16'(23153 + $urandom_range(500));
            c[6] = 16'(6190 + $urandom_range(100)); c[7] = 16'(4);
            c[8] = -16'(8711 + $urandom_range(200)); c[9] = 16'(2868 + $urandom_range(100));
            c[10] = 16'($urandom_range(100));
        end else if (mode == 1) begin
            foreach (c[i]) c[i] = 16'hFFFF;
        end else if (mode == 2) begin
            foreach (c[i]) c[i] = 16'h8000;
            c[3] = 16'h0000;
        end
        write_reg(bsc_pkg::CFG_AC_FIRST, {c[0], c[1], c[2]});
        write_reg(bsc_pkg::CFG_AC_SECOND, {c[3], c[4], c[5]});
        write_reg(bsc_pkg::CFG_B_PAIR, {16'd0, c[6], c[7]});
        write_reg(bsc_pkg::CFG_M_PAIR, {16'd0, c[8], c[9]});
    endtask

    function automatic bsc_pkg::in_t make_item(input logic kind, input logic [23:0] raw);
        bsc_pkg::in_t it;
        it.req_type = kind;
        it.raw_value = raw;
        return it;
    endfunction

    task automatic random_items(input int count);
        repeat (count) begin
            if ($urandom_range(9) < 7)
                pending_items.push_back(make_item(1'($urandom_range(1)),
                    $urandom_range(1) ? 24'(20000 + $urandom_range(20000)) :
                    24'(24'h500000 + $urandom_range(24'h300000))));
            else
                pending_items.push_back(make_item(1'($urandom_range(1)), 24'($urandom)));
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        error_count = 0;
        cycle_count = 0;
        hold_cycles = 0;
        send_pause = 1'b0;
        send_idle_pct = 36;
        recv_idle_pct = 88;
        coef_ac_first = '0;
        coef_ac_second = '0;
        coef_b_pair = '0;
        coef_m_pair = '0;
        coef_oss = bsc_pkg::OSS_RESET;
        model_b5 = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Pressure before any temperature uses the reset b5 and zero calibration.
        pending_items.push_back(make_item(bsc_pkg::KIND_PRESS, 24'h123456));
        pending_items.push_back(make_item(bsc_pkg::KIND_TEMP, 24'h000000));
        drain();

        // Directed: typical calibration, field extremes, ignored high bits.
        load_calibration(0);
        write_reg(CFG_UNUSED_INDEX, 48'hFFFF_FFFF_FFFF);
        write_reg(bsc_pkg::CFG_OSS, 48'd0);
        pending_items.push_back(make_item(bsc_pkg::KIND_TEMP, 24'h006C50));
        pending_items.push_back(make_item(bsc_pkg::KIND_PRESS, 24'h5D23C0));
        pending_items.push_back(make_item(bsc_pkg::KIND_TEMP, 24'hFF6C50));
        pending_items.push_back(make_item(bsc_pkg::KIND_TEMP, 24'h00FFFF));
        pending_items.push_back(make_item(bsc_pkg::KIND_PRESS, 24'hFFFFFF));
        pending_items.push_back(make_item(bsc_pkg::KIND_TEMP, 24'h000000));
        pending_items.push_back(make_item(bsc_pkg::KIND_PRESS, 24'h000000));
        drain();
        write_reg(bsc_pkg::CFG_OSS, 48'd3);
        pending_items.push_back(make_item(bsc_pkg::KIND_PRESS, 24'hFFFFFF));
        pending_items.push_back(make_item(bsc_pkg::KIND_PRESS, 24'h000000));
        drain();
        // Temperature zero divisor: ac5 zero and md zero, then b4 zero via ac4.
        write_reg(bsc_pkg::CFG_AC_SECOND, 48'h0000_0000_1234);
        write_reg(bsc_pkg::CFG_M_PAIR, 48'h0000_1234_0000);
        pending_items.push_back(make_item(bsc_pkg::KIND_TEMP, 24'h00ABCD));
        pending_items.push_back(make_item(bsc_pkg::KIND_PRESS, 24'h800000));
        drain();
        // All-ones and most-negative calibrations reach the large-b4 and wrap paths.
        load_calibration(1);
        write_reg(bsc_pkg::CFG_OSS, 48'd2);
        pending_items.push_back(make_item(bsc_pkg::KIND_TEMP, 24'h00FFFF));
        pending_items.push_back(make_item(bsc_pkg::KIND_PRESS, 24'hFFFFFF));
        pending_items.push_back(make_item(bsc_pkg::KIND_PRESS, 24'h000001));
        drain();
        load_calibration(2);
        pending_items.push_back(make_item(bsc_pkg::KIND_TEMP, 24'h000000));
        pending_items.push_back(make_item(bsc_pkg::KIND_PRESS, 24'hAAAAAA));
        pending_items.push_back(make_item(bsc_pkg::KIND_TEMP, 24'h555555));
        drain();

        // Random phases under the three idling profiles and several settings.
        for (int phase = 0; phase < 6; phase++) begin
            send_idle_pct = (phase < 2) ? 36 : (phase < 4) ? 88 : 0;
            recv_idle_pct = (phase < 2) ? 88 : (phase < 4) ? 36 : 0;
            load_calibration(phase == 5 ? 3 : 0);
            write_reg(bsc_pkg::CFG_OSS, 48'(phase % 4));
            random_items(240);
            if (phase == 4) begin
                // Long receiver hold-off while the sender keeps offering.
                hold_cycles = 1500;
            end
            if (phase == 2) begin
                while (pending_items.size() > 120) @(posedge aclk);
                send_pause = 1'b1;
                while (s_valid || expected_results.size() > 0) @(posedge aclk);
                send_pause = 1'b0;
            end
            drain();
        end

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
